@@ rtl/core/bhpq_pkg.sv @@
`default_nettype none

package bhpq_pkg;

  localparam int KEY_W  = 16;
  localparam int PRI_W  = 32;
  localparam int STAT_W = 2;
  localparam int FILL_W = 11;

  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_REMOVE = 1'b1;

  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

  localparam logic ORDER_MIN = 1'b0;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [PRI_W-1:0] pri;
  } entry_t;

  // True when priority a belongs above priority b. A min-heap is strict and
  // a max-heap lets equal priorities rise.
  function automatic logic above(input logic order, input logic [PRI_W-1:0] a,
                                 input logic [PRI_W-1:0] b);
    logic res;
    if (order == ORDER_MIN) begin
      res = (a < b);
    end else begin
      res = (a >= b);
    end
    return res;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/binary_heap_priority_queue_unit.sv @@
`default_nettype none

// Binary heap priority queue of (key, priority) entries held in one on-chip
// memory of DEPTH entries, heap position p living at address p-1. The
// configuration bit selects a min-heap (smallest priority at the root) or a
// max-heap (largest at the root); it is written through the cfg_ port, which
// is always ready, and the user must write it only while no request is in
// flight: the block itself does not enforce this. An insert request appends
// the entry and sifts it up; a remove request returns the root, moves the last
// entry to the root and sifts it down. A remove on an empty heap or an insert
// on a full heap reports its status and leaves the heap untouched. Every
// request yields exactly one result, carrying the fill count after the
// request. Requests are handled one at a time: the sift loop visits one heap
// level at a time, and each level waits on the registered read of the memory
// before it can compare and write back. A finished result sits in the output
// register while the next request is taken in. No clearing pass is needed
// after reset: only positions up to the fill count are used.
module binary_heap_priority_queue_unit #(
  parameter int DEPTH = 1024
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,

  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic                          in_kind,
  input  wire logic [bhpq_pkg::KEY_W-1:0]    in_entry_key,
  input  wire logic [bhpq_pkg::PRI_W-1:0]    in_entry_priority,

  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [bhpq_pkg::KEY_W-1:0]         out_root_key,
  output logic [bhpq_pkg::PRI_W-1:0]         out_root_priority,
  output logic [bhpq_pkg::STAT_W-1:0]        out_status,
  output logic [bhpq_pkg::FILL_W-1:0]        out_fill_count,

  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic                          cfg_heap_order
);

  // Count holds 0..DEPTH; child positions reach twice the count.
  localparam int CW = $clog2(DEPTH + 1);
  localparam int PW = CW + 1;
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int FW = bhpq_pkg::FILL_W;
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
  localparam logic [CW-1:0] ONE_C   = CW'(1);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_UP_RD  = 3'd1;
  localparam logic [2:0] S_UP_CMP = 3'd2;
  localparam logic [2:0] S_RM_LD  = 3'd3;
  localparam logic [2:0] S_DN_RD  = 3'd4;
  localparam logic [2:0] S_DN_CMP = 3'd5;
  localparam logic [2:0] S_OUT    = 3'd6;

  logic [2:0]                  state_r, state_nxt;
  logic [CW-1:0]               cnt_r, cnt_nxt;
  logic [CW-1:0]               hole_r, hole_nxt;
  bhpq_pkg::entry_t            item_r, item_nxt;
  bhpq_pkg::entry_t            res_r, res_nxt;
  logic [bhpq_pkg::STAT_W-1:0] stat_r, stat_nxt;
  logic                        order_r;

  logic                        out_valid_r;
  bhpq_pkg::entry_t            out_res_r;
  logic [bhpq_pkg::STAT_W-1:0] out_stat_r;
  logic [FW-1:0]               out_fill_r;
  logic                        out_load;

  logic                        wr_en;
  logic [AW-1:0]               wr_addr;
  bhpq_pkg::entry_t            wr_data;
  logic [AW-1:0]               rd_addr_a;
  logic [AW-1:0]               rd_addr_b;
  bhpq_pkg::entry_t            rd_data_a;
  bhpq_pkg::entry_t            rd_data_b;

  logic                        in_accept;
  logic [PW-1:0]               child;
  logic [CW-1:0]               parent;
  logic                        take_right;
  logic                        left_up;
  logic                        right_up;
  logic                        parent_down;

  bhpq_store #(.DEPTH(DEPTH)) u_store (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (rd_addr_b),
    .rd_data_a (rd_data_a),
    .rd_data_b (rd_data_b)
  );

  assign in_stall  = (state_r != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  // Left child of the hole, and the hole's parent for the climb.
  assign child  = {hole_r, 1'b0};
  assign parent = hole_r >> 1;

  // All three priority compares of a descent step run side by side; the
  // right child only competes when it exists.
  assign take_right  = (child != {1'b0, cnt_r}) &&
                       bhpq_pkg::above(order_r, rd_data_b.pri, rd_data_a.pri);
  assign left_up     = bhpq_pkg::above(order_r, rd_data_a.pri, item_r.pri);
  assign right_up    = bhpq_pkg::above(order_r, rd_data_b.pri, item_r.pri);
  assign parent_down = bhpq_pkg::above(order_r, item_r.pri, rd_data_a.pri);

  assign out_load = (state_r == S_OUT) && (!out_valid_r || !out_stall);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    hole_nxt  = hole_r;
    item_nxt  = item_r;
    res_nxt   = res_r;
    stat_nxt  = stat_r;
    wr_en     = 1'b0;
    wr_addr   = AW'(hole_r - ONE_C);
    wr_data   = item_r;
    rd_addr_a = '0;
    rd_addr_b = AW'(cnt_r - ONE_C);

    unique case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          res_nxt  = '0;
          stat_nxt = bhpq_pkg::STAT_OK;
          if (in_kind == bhpq_pkg::KIND_INSERT) begin
            if (cnt_r == DEPTH_C) begin
              stat_nxt  = bhpq_pkg::STAT_FULL;
              state_nxt = S_OUT;
            end else begin
              cnt_nxt       = cnt_r + ONE_C;
              hole_nxt      = cnt_r + ONE_C;
              item_nxt.key  = in_entry_key;
              item_nxt.pri  = in_entry_priority;
              state_nxt     = S_UP_RD;
            end
          end else begin
            if (cnt_r == '0) begin
              stat_nxt  = bhpq_pkg::STAT_EMPTY;
              state_nxt = S_OUT;
            end else begin
              // Root on port a, last entry on port b.
              state_nxt = S_RM_LD;
            end
          end
        end
      end

      S_RM_LD: begin
        res_nxt  = rd_data_a;
        item_nxt = rd_data_b;
        cnt_nxt  = cnt_r - ONE_C;
        hole_nxt = ONE_C;
        if (cnt_r == ONE_C) begin
          state_nxt = S_OUT;
        end else begin
          state_nxt = S_DN_RD;
        end
      end

      S_UP_RD: begin
        rd_addr_a = AW'(parent - ONE_C);
        if (hole_r == ONE_C) begin
          wr_en     = 1'b1;
          state_nxt = S_OUT;
        end else begin
          state_nxt = S_UP_CMP;
        end
      end

      S_UP_CMP: begin
        wr_en = 1'b1;
        if (parent_down) begin
          wr_data   = rd_data_a;
          hole_nxt  = parent;
          state_nxt = S_UP_RD;
        end else begin
          state_nxt = S_OUT;
        end
      end

      S_DN_RD: begin
        rd_addr_a = AW'(child - PW'(1));
        rd_addr_b = AW'(child);
        if (child > {1'b0, cnt_r}) begin
          wr_en     = 1'b1;
          state_nxt = S_OUT;
        end else begin
          state_nxt = S_DN_CMP;
        end
      end

      S_DN_CMP: begin
        wr_en = 1'b1;
        if (take_right ? right_up : left_up) begin
          wr_data   = take_right ? rd_data_b : rd_data_a;
          hole_nxt  = take_right ? CW'(child + PW'(1)) : CW'(child);
          state_nxt = S_DN_RD;
        end else begin
          state_nxt = S_OUT;
        end
      end

      S_OUT: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      order_r     <= bhpq_pkg::ORDER_MIN;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      if (cfg_valid && cfg_ready) begin
        order_r <= cfg_heap_order;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Working and result payload registers need no reset.
  always_ff @(posedge clk) begin
    hole_r <= hole_nxt;
    item_r <= item_nxt;
    res_r  <= res_nxt;
    stat_r <= stat_nxt;
    if (out_load) begin
      out_res_r  <= res_r;
      out_stat_r <= stat_r;
      out_fill_r <= FW'(cnt_r);
    end
  end

  assign out_valid         = out_valid_r;
  assign out_root_key      = out_res_r.key;
  assign out_root_priority = out_res_r.pri;
  assign out_status        = out_stat_r;
  assign out_fill_count    = out_fill_r;

endmodule

`default_nettype wire

@@ rtl/core/bhpq_store.sv @@
`default_nettype none

module bhpq_store #(
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire bhpq_pkg::entry_t wr_data,
  input  wire logic [AW-1:0]    rd_addr_a,
  input  wire logic [AW-1:0]    rd_addr_b,
  output bhpq_pkg::entry_t      rd_data_a,
  output bhpq_pkg::entry_t      rd_data_b
);

  // One write port and two read ports, read data registered.
  bhpq_pkg::entry_t mem [DEPTH];
  bhpq_pkg::entry_t rd_data_a_r;
  bhpq_pkg::entry_t rd_data_b_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_a_r <= mem[rd_addr_a];
    rd_data_b_r <= mem[rd_addr_b];
  end

  assign rd_data_a = rd_data_a_r;
  assign rd_data_b = rd_data_b_r;

endmodule

`default_nettype wire
